/* sv/nps_pkg.sv */
// Shared types and constants for the nearest particle grid sampler.
// Depends on nothing; every other file of the block refers to it by scoped names.
package nps_pkg;

    // Store geometry.
    localparam int MAX_PARTICLES = 1024;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = IDX_W + 1;

    // Number formats.
    localparam int POS_W           = 16;
    localparam int DEN_W           = 16;
    localparam int COORD_FRAC_BITS = 14;
    localparam int STEP_W          = $clog2(COORD_FRAC_BITS);
    localparam int LAT_W           = 10;
    localparam int GRID_W          = 11;
    localparam int DIST_W          = 32;
    localparam int DIFF_W          = POS_W;
    localparam int SQ_W            = 2 * DIFF_W;
    localparam int SUM_W           = SQ_W + 2;

    // Register defaults.
    localparam logic [GRID_W-1:0] GRID_SIZE_RESET = GRID_W'(64);
    localparam logic [DIST_W-1:0] MAX_DIST_RESET  = DIST_W'(107584);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE = 2'd0,
        CFG_MAX_DIST  = 2'd1
    } cfg_index_t;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // Command handed from the front to the back. For a load the three
    // positions hold x, y, z; for a query they hold the lattice coordinates.
    typedef struct packed {
        op_t                    op;
        logic signed [POS_W-1:0] a;
        logic signed [POS_W-1:0] b;
        logic signed [POS_W-1:0] c;
        logic [DEN_W-1:0]       density;
    } cmd_t;

    // One store entry.
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [DEN_W-1:0]       density;
    } particle_t;

endpackage

/* sv/nps_item_if.sv */
// Input item channel of the nearest particle grid sampler.
// Depends on nps_pkg for field widths.
interface nps_item_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           operation;
    logic signed [nps_pkg::POS_W-1:0]     pos_x;
    logic signed [nps_pkg::POS_W-1:0]     pos_y;
    logic signed [nps_pkg::POS_W-1:0]     pos_z;
    logic [nps_pkg::DEN_W-1:0]            particle_density;
    logic [nps_pkg::LAT_W-1:0]            grid_i;
    logic [nps_pkg::LAT_W-1:0]            grid_j;
    logic [nps_pkg::LAT_W-1:0]            grid_k;

    modport source (
        output valid, operation, pos_x, pos_y, pos_z, particle_density,
               grid_i, grid_j, grid_k,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_y, pos_z, particle_density,
               grid_i, grid_j, grid_k,
        output ready
    );
endinterface

/* sv/nps_result_if.sv */
// Result channel of the nearest particle grid sampler.
// Depends on nps_pkg for field widths.
interface nps_result_if;
    logic                          valid;
    logic                          ready;
    logic [nps_pkg::DEN_W-1:0]     sampled_density;
    logic                          hit;
    logic [nps_pkg::IDX_W-1:0]     nearest_index;

    modport source (
        output valid, sampled_density, hit, nearest_index,
        input  ready
    );
    modport sink (
        input  valid, sampled_density, hit, nearest_index,
        output ready
    );
endinterface

/* sv/nps_cfg_if.sv */
// Configuration write channel of the nearest particle grid sampler.
// Depends on nps_pkg for the index and data widths.
interface nps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [nps_pkg::CFG_IDX_W-1:0]     index;
    logic [nps_pkg::DIST_W-1:0]        data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* sv/nps_queue.sv */
// Short command queue that decouples the front from the back.
// Depends on nps_pkg for the command type and depth.
module nps_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nps_pkg::cmd_t  push_data,
    input  logic           pop,
    output nps_pkg::cmd_t  head,
    output logic           full,
    output logic           empty
);

    nps_pkg::cmd_t                entries [nps_pkg::QUEUE_DEPTH];
    logic [nps_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [nps_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [nps_pkg::QPTR_W:0]     fill_reg, fill_next;
    logic                         do_push;
    logic                         do_pop;

    // Status and guarded strobes.
    assign full    = (fill_reg == (nps_pkg::QPTR_W+1)'(nps_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries[rd_ptr_reg];

    // Pointer and fill updates.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/nps_front.sv */
// Front part: configuration registers, item intake, and the serial dividers
// that turn lattice indices into coordinates. Depends on nps_pkg and the
// item and configuration interfaces.
module nps_front (
    input  logic                          clk,
    input  logic                          rst_n,
    nps_item_if.sink                      item,
    nps_cfg_if.sink                       cfg,
    output logic                          push,
    output nps_pkg::cmd_t                 push_data,
    input  logic                          queue_full,
    output logic [nps_pkg::DIST_W-1:0]    max_distance_sq
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    localparam int GW = nps_pkg::GRID_W;
    localparam int QW = nps_pkg::COORD_FRAC_BITS;

    front_state_t                     state_reg;
    logic [nps_pkg::STEP_W-1:0]       step_reg;
    logic [GW-1:0]                    grid_size_reg;
    logic [nps_pkg::DIST_W-1:0]       max_dist_reg;
    logic [GW-1:0]                    divisor_reg;
    logic [GW-1:0]                    rem_x_reg, rem_y_reg, rem_z_reg;
    logic [QW-1:0]                    quo_x_reg, quo_y_reg, quo_z_reg;
    logic [GW-1:0]                    divisor_next;
    logic [GW:0]                      step_x, step_y, step_z;
    logic                             accept;
    nps_pkg::op_t                     item_op;

    // Clamp an index to the last lattice point.
    function automatic logic [GW-1:0] sat_index(
        input logic [nps_pkg::LAT_W-1:0] idx,
        input logic [GW-1:0]             n
    );
        logic [GW-1:0] wide;
        wide = {1'b0, idx};
        if (wide >= n)
        begin
            return n - 1'b1;
        end
        return wide;
    endfunction

    // One restoring division step: quotient bit on top, new remainder below.
    function automatic logic [GW:0] div_step(
        input logic [GW-1:0] rem,
        input logic [GW-1:0] n
    );
        logic [GW:0] shifted;
        logic [GW:0] diff;
        shifted = {rem, 1'b0};
        diff    = shifted - {1'b0, n};
        if (shifted >= {1'b0, n})
        begin
            return {1'b1, diff[GW-1:0]};
        end
        return {1'b0, shifted[GW-1:0]};
    endfunction

    // Configuration port is always ready.
    assign cfg.ready       = 1'b1;
    assign max_distance_sq = max_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= nps_pkg::GRID_SIZE_RESET;
            max_dist_reg  <= nps_pkg::MAX_DIST_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (nps_pkg::cfg_index_t'(cfg.index))
                nps_pkg::CFG_GRID_SIZE: grid_size_reg <= cfg.data[GW-1:0];
                nps_pkg::CFG_MAX_DIST:  max_dist_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // Intake handshake and classification.
    assign item.ready   = (state_reg == F_IDLE) && !queue_full;
    assign accept       = item.valid && item.ready;
    assign item_op      = nps_pkg::op_t'(item.operation);
    assign divisor_next = (grid_size_reg == '0) ? GW'(1) : grid_size_reg;

    assign step_x = div_step(rem_x_reg, divisor_reg);
    assign step_y = div_step(rem_y_reg, divisor_reg);
    assign step_z = div_step(rem_z_reg, divisor_reg);

    // Queue write: loads and clears go straight in, queries after division.
    always_comb
    begin
        push      = 1'b0;
        push_data = '0;
        if (state_reg == F_PUSH)
        begin
            push              = !queue_full;
            push_data.op      = nps_pkg::OP_QUERY;
            push_data.a       = $signed({{(nps_pkg::POS_W-QW){1'b0}}, quo_x_reg});
            push_data.b       = $signed({{(nps_pkg::POS_W-QW){1'b0}}, quo_y_reg});
            push_data.c       = $signed({{(nps_pkg::POS_W-QW){1'b0}}, quo_z_reg});
        end
        else
        begin
            push_data.op      = item_op;
            push_data.a       = item.pos_x;
            push_data.b       = item.pos_y;
            push_data.c       = item.pos_z;
            push_data.density = item.particle_density;
            push = accept
                && (item.operation == nps_pkg::OP_CLEAR || item.operation == nps_pkg::OP_LOAD);
        end
    end

    // Front sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    step_reg <= '0;
                    if (accept && item.operation == nps_pkg::OP_QUERY)
                    begin
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == nps_pkg::STEP_W'(QW - 1))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!queue_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // Divider datapath: k gives x, j gives y, i gives z.
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE)
        begin
            divisor_reg <= divisor_next;
            rem_x_reg   <= sat_index(item.grid_k, divisor_next);
            rem_y_reg   <= sat_index(item.grid_j, divisor_next);
            rem_z_reg   <= sat_index(item.grid_i, divisor_next);
            quo_x_reg   <= '0;
            quo_y_reg   <= '0;
            quo_z_reg   <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            rem_x_reg <= step_x[GW-1:0];
            rem_y_reg <= step_y[GW-1:0];
            rem_z_reg <= step_z[GW-1:0];
            quo_x_reg <= {quo_x_reg[QW-2:0], step_x[GW]};
            quo_y_reg <= {quo_y_reg[QW-2:0], step_y[GW]};
            quo_z_reg <= {quo_z_reg[QW-2:0], step_z[GW]};
        end
    end

endmodule

/* sv/nps_back.sv */
// Back part: particle store, scan pipeline for the nearest particle, and the
// result register. Depends on nps_pkg and the result interface.
module nps_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nps_pkg::cmd_t                 head,
    input  logic                          queue_empty,
    output logic                          pop,
    input  logic [nps_pkg::DIST_W-1:0]    max_distance_sq,
    nps_result_if.source                  result
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } back_state_t;

    localparam int QW = nps_pkg::COORD_FRAC_BITS;

    // Particle store.
    nps_pkg::particle_t               store_mem [nps_pkg::MAX_PARTICLES];

    back_state_t                      state_reg;
    logic [nps_pkg::CNT_W-1:0]        count_reg;
    logic [nps_pkg::CNT_W-1:0]        addr_reg;
    logic [QW-1:0]                    cx_reg, cy_reg, cz_reg;
    logic                             found_reg;

    // Pipeline stage 1: store read.
    logic                             rd_valid_reg;
    logic [nps_pkg::IDX_W-1:0]        rd_idx_reg;
    nps_pkg::particle_t               rd_data_reg;
    // Stage 2: absolute differences.
    logic                             ad_valid_reg;
    logic [nps_pkg::IDX_W-1:0]        ad_idx_reg;
    logic [nps_pkg::DIFF_W-1:0]       ad_x_reg, ad_y_reg, ad_z_reg;
    logic [nps_pkg::DEN_W-1:0]        ad_den_reg;
    // Stage 3: squares.
    logic                             sq_valid_reg;
    logic [nps_pkg::IDX_W-1:0]        sq_idx_reg;
    logic [nps_pkg::SQ_W-1:0]         sq_x_reg, sq_y_reg, sq_z_reg;
    logic [nps_pkg::DEN_W-1:0]        sq_den_reg;
    // Running minimum.
    logic [nps_pkg::SUM_W-1:0]        best_dist_reg;
    logic [nps_pkg::IDX_W-1:0]        best_idx_reg;
    logic [nps_pkg::DEN_W-1:0]        best_den_reg;

    // Result register.
    logic                             out_valid_reg;
    logic [nps_pkg::DEN_W-1:0]        out_den_reg;
    logic                             out_hit_reg;
    logic [nps_pkg::IDX_W-1:0]        out_idx_reg;

    logic                             issue;
    logic                             load_we;
    logic                             scan_over;
    logic                             take_min;
    logic                             hit;
    logic                             out_free;
    logic [nps_pkg::SUM_W-1:0]        dist_sum;
    logic [nps_pkg::DIFF_W-1:0]       diff_x, diff_y, diff_z;

    // Magnitude of a position minus a nonnegative lattice coordinate.
    function automatic logic [nps_pkg::DIFF_W-1:0] abs_diff(
        input logic signed [nps_pkg::POS_W-1:0] p,
        input logic [QW-1:0]                    c
    );
        logic signed [nps_pkg::POS_W:0] p_ext;
        logic signed [nps_pkg::POS_W:0] c_ext;
        logic signed [nps_pkg::POS_W:0] d;
        logic signed [nps_pkg::POS_W:0] neg;
        p_ext = $signed({p[nps_pkg::POS_W-1], p});
        c_ext = $signed({{(nps_pkg::POS_W+1-QW){1'b0}}, c});
        d     = p_ext - c_ext;
        neg   = -d;
        if (d[nps_pkg::POS_W])
        begin
            return neg[nps_pkg::DIFF_W-1:0];
        end
        return d[nps_pkg::DIFF_W-1:0];
    endfunction

    // Command intake and control strobes.
    assign pop       = (state_reg == B_IDLE) && !queue_empty;
    assign load_we   = pop && head.op == nps_pkg::OP_LOAD
                       && count_reg != nps_pkg::CNT_W'(nps_pkg::MAX_PARTICLES);
    assign issue     = (state_reg == B_SCAN) && (addr_reg != count_reg);
    assign scan_over = (state_reg == B_SCAN) && (addr_reg == count_reg)
                       && !rd_valid_reg && !ad_valid_reg && !sq_valid_reg;
    assign out_free  = !out_valid_reg || result.ready;

    // Distance of the particle in the last stage and the running compare.
    assign dist_sum = nps_pkg::SUM_W'(sq_x_reg) + nps_pkg::SUM_W'(sq_y_reg)
                    + nps_pkg::SUM_W'(sq_z_reg);
    assign take_min = sq_valid_reg && (!found_reg || dist_sum < best_dist_reg);
    assign hit      = found_reg
                      && best_dist_reg <= nps_pkg::SUM_W'(max_distance_sq);

    assign diff_x = abs_diff(rd_data_reg.x, cx_reg);
    assign diff_y = abs_diff(rd_data_reg.y, cy_reg);
    assign diff_z = abs_diff(rd_data_reg.z, cz_reg);

    // Store write and registered read.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            store_mem[count_reg[nps_pkg::IDX_W-1:0]] <= {head.a, head.b, head.c, head.density};
        end
        rd_data_reg <= store_mem[addr_reg[nps_pkg::IDX_W-1:0]];
    end

    // Back sequencer, stage valids and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            found_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            ad_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            ad_valid_reg <= rd_valid_reg;
            sq_valid_reg <= ad_valid_reg;
            if (take_min)
            begin
                found_reg <= 1'b1;
            end
            if (state_reg == B_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    addr_reg  <= '0;
                    found_reg <= 1'b0;
                    if (pop)
                    begin
                        unique case (head.op)
                            nps_pkg::OP_CLEAR: count_reg <= '0;
                            nps_pkg::OP_LOAD:
                            begin
                                if (load_we)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            nps_pkg::OP_QUERY:
                            begin
                                state_reg <= (count_reg == '0) ? B_DONE : B_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                B_SCAN:
                begin
                    if (issue)
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                    if (scan_over)
                    begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        out_den_reg   <= hit ? best_den_reg : '0;
                        out_hit_reg   <= hit;
                        out_idx_reg   <= found_reg ? best_idx_reg : '0;
                        state_reg     <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Scan datapath.
    always_ff @(posedge clk)
    begin
        if (pop && head.op == nps_pkg::OP_QUERY)
        begin
            cx_reg <= head.a[QW-1:0];
            cy_reg <= head.b[QW-1:0];
            cz_reg <= head.c[QW-1:0];
        end
        rd_idx_reg <= addr_reg[nps_pkg::IDX_W-1:0];

        ad_idx_reg <= rd_idx_reg;
        ad_x_reg   <= diff_x;
        ad_y_reg   <= diff_y;
        ad_z_reg   <= diff_z;
        ad_den_reg <= rd_data_reg.density;

        sq_idx_reg <= ad_idx_reg;
        sq_x_reg   <= nps_pkg::SQ_W'(ad_x_reg) * nps_pkg::SQ_W'(ad_x_reg);
        sq_y_reg   <= nps_pkg::SQ_W'(ad_y_reg) * nps_pkg::SQ_W'(ad_y_reg);
        sq_z_reg   <= nps_pkg::SQ_W'(ad_z_reg) * nps_pkg::SQ_W'(ad_z_reg);
        sq_den_reg <= ad_den_reg;

        if (take_min)
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= sq_idx_reg;
            best_den_reg  <= sq_den_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.sampled_density = out_den_reg;
    assign result.hit             = out_hit_reg;
    assign result.nearest_index   = out_idx_reg;

endmodule

/* sv/nearest_particle_grid_sampler.sv */
// Top level of the nearest particle grid sampler.
// Depends on nps_pkg, the three channel interfaces, nps_front, nps_queue and nps_back.
//
// Usage: items arrive on the item channel. A clear beat empties the store, a load beat
// appends one particle (ignored once the store holds 1024), a query beat names lattice
// point (i,j,k) and yields exactly one beat on the result channel; operation code 3 is
// dropped. The cfg channel writes grid_size (index 0) and max_distance_sq (index 1); it is
// always ready; the user must write it only while the block is idle; this is not enforced.
// Flow: a query first passes the front, where three serial dividers produce one
// coordinate bit per cycle, then the back, whose scan reads one store entry per cycle
// through a distance pipeline of store read, absolute differences and squares feeding a
// running minimum; the back takes clears and loads without leaving its idle state.
// Stalls: a finished result waits in the output register while the back keeps taking
// clears and loads from a four-entry command queue; a later query holds its result until
// the register frees, and item ready drops once the queue is full.
// Reset: store empty, grid_size 64, max_distance_sq 107584, no result pending.
module nearest_particle_grid_sampler (
    input  logic          clk,
    input  logic          rst_n,
    nps_item_if.sink      item,
    nps_result_if.source  result,
    nps_cfg_if.sink       cfg
);

    logic                          push;
    nps_pkg::cmd_t                 push_data;
    logic                          pop;
    nps_pkg::cmd_t                 head;
    logic                          queue_full;
    logic                          queue_empty;
    logic [nps_pkg::DIST_W-1:0]    max_distance_sq;

    // Intake, configuration and coordinate division.
    nps_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .cfg             (cfg),
        .push            (push),
        .push_data       (push_data),
        .queue_full      (queue_full),
        .max_distance_sq (max_distance_sq)
    );

    // Command queue between the two halves.
    nps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Store, scan and result.
    nps_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .queue_empty     (queue_empty),
        .pop             (pop),
        .max_distance_sq (max_distance_sq),
        .result          (result)
    );

endmodule
